>>> rtl/terminal_key_sequence_decoder_macros.svh
// assertion helpers for the terminal key decoder checker
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_MACROS_SVH

// same-cycle implication, checked outside reset
`define TKSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tksd check failed");

// next-cycle implication, checked outside reset
`define TKSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tksd check failed");

`endif

>>> rtl/tksd_pkg.sv
package tksd_pkg;

    localparam int CNT_W  = 6;
    localparam int IDLE_W = 10;

    // request codes
    localparam logic [1:0] REQ_BYTE   = 2'd0;
    localparam logic [1:0] REQ_TICK   = 2'd1;
    localparam logic [1:0] REQ_CLOSED = 2'd2;

    // key codes
    localparam logic [2:0] KEY_UP     = 3'd0;
    localparam logic [2:0] KEY_DN     = 3'd1;
    localparam logic [2:0] KEY_RETURN = 3'd2;
    localparam logic [2:0] KEY_INTR   = 3'd3;
    localparam logic [2:0] KEY_EOF    = 3'd4;
    localparam logic [2:0] KEY_TEXT   = 3'd5;
    localparam logic [2:0] KEY_ESC    = 3'd6;

    // byte values
    localparam logic [7:0] BYTE_ESC   = 8'h1b;
    localparam logic [7:0] BYTE_CR    = 8'h0d;
    localparam logic [7:0] BYTE_LF    = 8'h0a;
    localparam logic [7:0] BYTE_ETX   = 8'h03;
    localparam logic [7:0] BYTE_EOT   = 8'h04;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_DEL   = 8'h7f;
    localparam logic [7:0] BYTE_CSI   = 8'h5b;
    localparam logic [7:0] BYTE_SS3   = 8'h4f;
    localparam logic [7:0] BYTE_UP    = 8'h41;
    localparam logic [7:0] BYTE_DOWN  = 8'h42;
    localparam logic [7:0] BYTE_FIN_LO = 8'h40;
    localparam logic [7:0] BYTE_FIN_HI = 8'h7e;

    localparam logic [IDLE_W-1:0] TIMEOUT_RST = 10'd75;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0] key_code;
        logic [6:0] char_code;
    } t_out_item;

endpackage

>>> rtl/terminal_key_sequence_decoder.sv
// channel   dir  handshake                  payload
// in        in   i_in_valid / o_in_stall    i_in_data  (t_in_item)
// out       out  o_out_valid / i_out_stall  o_out_data (t_out_item)
// cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_data (escape timeout)
//
// one item per cycle sustained while the output is not stalled; an item waits in the input
// register and its key, if any, then goes into the result register
// the decode of one item against the sequence state is a single pass of logic
// reset (synchronous, active low) clears the sequence state and sets the
// timeout to 75 ticks; a stalled output holds the result register, and the input register when full
module terminal_key_sequence_decoder
    import tksd_pkg::*;
#(
    parameter int BUFFER_BYTES = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    input  t_in_item     i_in_data,
    output logic         o_in_stall,
    output logic         o_out_valid,
    output t_out_item    o_out_data,
    input  logic         i_out_stall,
    input  logic         i_cfg_valid,
    input  logic [9:0]   i_cfg_data,
    output logic         o_cfg_ready
);

    // sequence phase
    typedef enum logic [1:0] {
        PH_NONE = 2'd0,
        PH_ESC  = 2'd1,
        PH_CSI  = 2'd2,
        PH_SS3  = 2'd3
    } t_phase;

    localparam logic [CNT_W-1:0] BufLimit = CNT_W'(BUFFER_BYTES);

    // input register
    logic                r_in_valid;
    t_in_item            r_in_item;
    // result register
    logic                r_out_valid;
    t_out_item           r_out_item;
    // sequence state and timeout register
    t_phase              r_phase,  n_phase;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic [IDLE_W-1:0]   r_idle,   n_idle;
    logic [IDLE_W-1:0]   r_timeout;

    logic                n_emit;
    t_out_item           n_item;
    logic                w_advance;
    logic [CNT_W-1:0]    w_count_inc;
    logic [IDLE_W-1:0]   w_idle_inc;
    logic [7:0]          w_b;

    // the decode stage moves whenever the result register is free or drains
    assign w_advance   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;
    // config must only arrive while idle; the block does not enforce this, and the port is always open
    assign o_cfg_ready = 1'b1;

    assign w_b         = r_in_item.data_byte;
    assign w_count_inc = r_count + 1'b1;
    // idle counter saturates at all ones
    assign w_idle_inc  = (r_idle == '1) ? r_idle : r_idle + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_idle  = r_idle;
        n_emit  = 1'b0;
        n_item  = '{key_code: KEY_UP, char_code: 7'd0};
        case (r_in_item.req_type)
            REQ_BYTE: begin
                n_idle = '0;
                case (r_phase)
                    PH_NONE: begin
                        if (w_b == BYTE_ESC) begin
                            n_phase = PH_ESC;
                            n_count = CNT_W'(1);
                        end else if (w_b == BYTE_CR || w_b == BYTE_LF) begin
                            n_emit = 1'b1;
                            n_item.key_code = KEY_RETURN;
                        end else if (w_b == BYTE_ETX) begin
                            n_emit = 1'b1;
                            n_item.key_code = KEY_INTR;
                        end else if (w_b == BYTE_EOT) begin
                            n_emit = 1'b1;
                            n_item.key_code = KEY_EOF;
                        end else if (w_b >= BYTE_SPACE && w_b < BYTE_DEL) begin
                            n_emit = 1'b1;
                            n_item.key_code  = KEY_TEXT;
                            n_item.char_code = w_b[6:0];
                        end
                    end
                    PH_ESC: begin
                        if (w_b == BYTE_CSI) begin
                            n_phase = PH_CSI;
                            n_count = CNT_W'(2);
                        end else if (w_b == BYTE_SS3) begin
                            n_phase = PH_SS3;
                            n_count = CNT_W'(2);
                        end else begin
                            // alt key, swallowed
                            n_phase = PH_NONE;
                            n_count = '0;
                        end
                    end
                    PH_SS3: begin
                        n_phase = PH_NONE;
                        n_count = '0;
                        if (w_b == BYTE_UP) begin
                            n_emit = 1'b1;
                            n_item.key_code = KEY_UP;
                        end else if (w_b == BYTE_DOWN) begin
                            n_emit = 1'b1;
                            n_item.key_code = KEY_DN;
                        end
                    end
                    default: begin
                        // inside csi: arrows only right after the bracket
                        if (r_count == CNT_W'(2) && w_b == BYTE_UP) begin
                            n_phase = PH_NONE;
                            n_count = '0;
                            n_emit  = 1'b1;
                            n_item.key_code = KEY_UP;
                        end else if (r_count == CNT_W'(2) && w_b == BYTE_DOWN) begin
                            n_phase = PH_NONE;
                            n_count = '0;
                            n_emit  = 1'b1;
                            n_item.key_code = KEY_DN;
                        end else if (w_b >= BYTE_FIN_LO && w_b <= BYTE_FIN_HI) begin
                            n_phase = PH_NONE;
                            n_count = '0;
                        end else if (w_count_inc >= BufLimit) begin
                            // overlong sequence dropped
                            n_phase = PH_NONE;
                            n_count = '0;
                        end else begin
                            n_count = w_count_inc;
                        end
                    end
                endcase
            end
            REQ_TICK: begin
                if (r_phase != PH_NONE) begin
                    if (w_idle_inc >= r_timeout) begin
                        // pending sequence after silence gives an escape key
                        n_phase = PH_NONE;
                        n_count = '0;
                        n_idle  = '0;
                        n_emit  = 1'b1;
                        n_item.key_code = KEY_ESC;
                    end else begin
                        n_idle = w_idle_inc;
                    end
                end
            end
            REQ_CLOSED: begin
                n_phase = PH_NONE;
                n_count = '0;
                n_idle  = '0;
                n_emit  = 1'b1;
                n_item.key_code = KEY_EOF;
            end
            default: begin
                // unknown request, no effect
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_NONE;
            r_count     <= '0;
            r_idle      <= '0;
            r_timeout   <= TIMEOUT_RST;
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            // input register takes a transfer when empty or moving on
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= r_in_valid && n_emit;
                if (r_in_valid) begin
                    r_phase <= n_phase;
                    r_count <= n_count;
                    r_idle  <= n_idle;
                end
            end
        end
        // payload registers
        if (!o_in_stall && i_in_valid) begin
            r_in_item <= i_in_data;
        end
        if (w_advance && r_in_valid && n_emit) begin
            r_out_item <= n_item;
        end
    end

endmodule

>>> rtl/tksd_checker.sv
`include "terminal_key_sequence_decoder_macros.svh"

module tksd_checker
    import tksd_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         o_in_stall,
    input  logic         o_out_valid,
    input  t_out_item    o_out_data,
    input  logic         i_out_stall
);

    logic w_is_text;
    logic w_printable;

    assign w_is_text   = (o_out_data.key_code == KEY_TEXT);
    assign w_printable = (o_out_data.char_code >= BYTE_SPACE[6:0]) &&
                         (o_out_data.char_code != BYTE_DEL[6:0]);

    // a stalled result stays put
    `TKSD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

    // only char keys carry a character
    `TKSD_ASSERT_NOW(a_char_zero, o_out_valid && !w_is_text, o_out_data.char_code == 7'd0)

    // char keys are printable
    `TKSD_ASSERT_NOW(a_char_print, o_out_valid && w_is_text, w_printable)

    // input side never stalls while the output drains freely
    `TKSD_ASSERT_NOW(a_no_stall, !i_out_stall, !o_in_stall)

endmodule

bind terminal_key_sequence_decoder tksd_checker u_tksd_checker (.*);

>>> tb/tb_terminal_key_sequence_decoder.sv
`timescale 1ns / 100ps

module tb_terminal_key_sequence_decoder;
    import tksd_pkg::*;

    localparam int BUF_BYTES    = 32;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;

    // request code with no meaning to the block, must be ignored
    localparam logic [1:0]        REQ_UNUSED = 2'd3;
    localparam logic [IDLE_W-1:0] IDLE_MAX   = '1;

    // escape sequence tracking in the key predictor
    typedef enum logic [1:0] {
        SEQ_NONE,
        SEQ_ESC,
        SEQ_CSI,
        SEQ_SS3
    } t_seq_phase;

    logic            clk       = 1'b0;
    logic            rst_n     = 1'b0;
    logic            in_valid  = 1'b0;
    t_in_item        in_data   = '0;
    logic            in_stall;
    logic            out_valid;
    t_out_item       out_data;
    logic            out_stall = 1'b0;
    logic            cfg_valid = 1'b0;
    logic [9:0]      cfg_data  = '0;
    logic            cfg_ready;

    // stimulus waiting for the driver, keys waiting for the monitor
    t_in_item        term_input[$];
    t_out_item       expected_keys[$];

    // key predictor state
    t_seq_phase        seq_phase   = SEQ_NONE;
    logic [CNT_W-1:0]  seq_len     = '0;
    logic [IDLE_W-1:0] idle_ticks  = '0;
    logic [IDLE_W-1:0] timeout_cfg = TIMEOUT_RST;

    int sender_idle_pct = 0;
    int stall_pct       = 0;
    int items_queued    = 0;
    int items_sent      = 0;
    int keys_seen       = 0;
    int timeout_writes  = 0;
    int mismatches      = 0;
    int cycle_count     = 0;

    terminal_key_sequence_decoder #(
        .BUFFER_BYTES(BUF_BYTES)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_stall (in_stall),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_stall(out_stall),
        .i_cfg_valid(cfg_valid),
        .i_cfg_data (cfg_data),
        .o_cfg_ready(cfg_ready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // key predictor
    // ------------------------------------------------------------------

    function automatic void drop_seq();
        seq_phase  = SEQ_NONE;
        seq_len    = '0;
        idle_ticks = '0;
    endfunction

    // advance the predictor by one accepted item, queue the key it yields
    function automatic void decode_item(input t_in_item it);
        t_out_item  key;
        logic       hit;
        logic [7:0] b;
        key = '0;
        hit = 1'b0;
        b   = it.data_byte;
        case (it.req_type)
            REQ_BYTE: begin
                idle_ticks = '0;
                case (seq_phase)
                    SEQ_NONE: begin
                        if (b == BYTE_ESC) begin
                            seq_phase = SEQ_ESC;
                            seq_len   = CNT_W'(1);
                        end else if (b == BYTE_CR || b == BYTE_LF) begin
                            hit = 1'b1;
                            key.key_code = KEY_RETURN;
                        end else if (b == BYTE_ETX) begin
                            hit = 1'b1;
                            key.key_code = KEY_INTR;
                        end else if (b == BYTE_EOT) begin
                            hit = 1'b1;
                            key.key_code = KEY_EOF;
                        end else if (b >= BYTE_SPACE && b < BYTE_DEL) begin
                            hit = 1'b1;
                            key.key_code  = KEY_TEXT;
                            key.char_code = b[6:0];
                        end
                    end
                    SEQ_ESC: begin
                        if (b == BYTE_CSI) begin
                            seq_phase = SEQ_CSI;
                            seq_len   = CNT_W'(2);
                        end else if (b == BYTE_SS3) begin
                            seq_phase = SEQ_SS3;
                            seq_len   = CNT_W'(2);
                        end else begin
                            // alt key, swallowed
                            drop_seq();
                        end
                    end
                    SEQ_SS3: begin
                        drop_seq();
                        if (b == BYTE_UP || b == BYTE_DOWN) begin
                            hit = 1'b1;
                            key.key_code = (b == BYTE_UP) ? KEY_UP : KEY_DN;
                        end
                    end
                    default: begin
                        if (seq_len == 2 && (b == BYTE_UP || b == BYTE_DOWN)) begin
                            drop_seq();
                            hit = 1'b1;
                            key.key_code = (b == BYTE_UP) ? KEY_UP : KEY_DN;
                        end else if (b >= BYTE_FIN_LO && b <= BYTE_FIN_HI) begin
                            drop_seq();
                        end else begin
                            // overlong csi is dropped without a key
                            seq_len = seq_len + 1'b1;
                            if (seq_len >= BUF_BYTES) drop_seq();
                        end
                    end
                endcase
            end
            REQ_TICK: begin
                if (seq_phase != SEQ_NONE) begin
                    if (idle_ticks != IDLE_MAX) idle_ticks = idle_ticks + 1'b1;
                    if (idle_ticks >= timeout_cfg) begin
                        drop_seq();
                        hit = 1'b1;
                        key.key_code = KEY_ESC;
                    end
                end
            end
            REQ_CLOSED: begin
                drop_seq();
                hit = 1'b1;
                key.key_code = KEY_EOF;
            end
            default: ;
        endcase
        if (hit) expected_keys.push_back(key);
    endfunction

    // ------------------------------------------------------------------
    // input driver: one transfer per accepted item, payload held while stalled
    // ------------------------------------------------------------------

    always @(posedge clk) begin
        logic busy;
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            busy = in_valid;
            if (in_valid && !in_stall) begin
                decode_item(in_data);
                items_sent++;
                busy = 1'b0;
            end
            if (!busy) begin
                if (term_input.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= term_input.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------
    // key monitor and checker
    // ------------------------------------------------------------------

    task automatic note_fail(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            keys_seen++;
            if (expected_keys.size() == 0) begin
                note_fail($sformatf("key with nothing expected: got key %0d char 0x%02h",
                                    out_data.key_code, out_data.char_code));
            end else begin
                want = expected_keys.pop_front();
                if (out_data.key_code != want.key_code ||
                    out_data.char_code != want.char_code) begin
                    note_fail($sformatf("key mismatch: expected key %0d char 0x%02h, got key %0d char 0x%02h",
                                        want.key_code, want.char_code,
                                        out_data.key_code, out_data.char_code));
                end
            end
        end
    end

    // hard stop in case the block hangs
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_terminal_key_sequence_decoder failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus builders
    // ------------------------------------------------------------------

    task automatic add_item(input logic [1:0] req, input logic [7:0] b);
        t_in_item it;
        it.req_type  = req;
        it.data_byte = b;
        term_input.push_back(it);
        items_queued++;
    endtask

    task automatic add_byte(input logic [7:0] b);
        add_item(REQ_BYTE, b);
    endtask

    // data byte is noise on ticks, closes and unused requests
    task automatic add_ticks(input int n);
        repeat (n) add_item(REQ_TICK, 8'($urandom_range(255)));
    endtask

    task automatic maybe_gap();
        if ($urandom_range(7) == 0) add_ticks($urandom_range(1, 3));
    endtask

    // one random burst: mostly well-formed keys and sequences, some noise
    task automatic gen_unit();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 28) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: add_byte(8'($urandom_range(BYTE_SPACE, BYTE_FIN_HI)));
                6: add_byte(8'($urandom_range(255)));
                7: add_byte($urandom_range(1) ? BYTE_CR : BYTE_LF);
                8: add_byte($urandom_range(1) ? BYTE_ETX : BYTE_EOT);
                default: add_byte(BYTE_ESC);
            endcase
        end else if (pick < 50) begin
            // arrow key, now and then with a bad final byte
            add_byte(BYTE_ESC);
            maybe_gap();
            add_byte($urandom_range(1) ? BYTE_CSI : BYTE_SS3);
            maybe_gap();
            if ($urandom_range(3) == 0) add_byte(8'($urandom_range(255)));
            else add_byte($urandom_range(1) ? BYTE_UP : BYTE_DOWN);
        end else if (pick < 65) begin
            // csi with parameters, sometimes long enough to overflow
            add_byte(BYTE_ESC);
            add_byte(BYTE_CSI);
            n = ($urandom_range(4) == 0) ? $urandom_range(BUF_BYTES - 7, BUF_BYTES + 2)
                                         : $urandom_range(0, 4);
            repeat (n) begin
                if ($urandom_range(7) == 0) add_byte(8'($urandom_range(255)));
                else add_byte(8'($urandom_range(8'h30, 8'h3f)));
                maybe_gap();
            end
            add_byte(8'($urandom_range(BYTE_FIN_LO, BYTE_FIN_HI)));
        end else if (pick < 73) begin
            add_byte(BYTE_ESC);
            add_byte(8'($urandom_range(255)));
        end else if (pick < 85) begin
            // pending sequence left to go quiet, around the timeout when it is at most 12
            add_byte(BYTE_ESC);
            case ($urandom_range(2))
                1: add_byte(BYTE_CSI);
                2: add_byte(BYTE_SS3);
                default: ;
            endcase
            if (timeout_cfg <= 12) add_ticks($urandom_range(0, timeout_cfg + 1));
            else add_ticks($urandom_range(0, 6));
        end else if (pick < 92) begin
            add_ticks(1);
        end else if (pick < 97) begin
            if ($urandom_range(1)) begin
                add_byte(BYTE_ESC);
                add_byte(BYTE_CSI);
            end
            add_item(REQ_CLOSED, 8'($urandom_range(255)));
        end else begin
            add_item(REQ_UNUSED, 8'($urandom_range(255)));
        end
    endtask

    // every plain byte class and each sequence shape once, timeout of 2
    task automatic load_directed();
        add_byte(BYTE_SPACE);
        add_byte(BYTE_FIN_HI);
        add_byte(8'h00);
        add_byte(8'hff);
        add_byte(BYTE_DEL);
        add_byte(BYTE_CR);
        add_byte(BYTE_LF);
        add_byte(BYTE_ETX);
        add_byte(BYTE_EOT);
        add_ticks(1);                               // nothing pending
        add_byte(BYTE_ESC); add_byte(BYTE_CSI); add_byte(BYTE_UP);
        add_byte(BYTE_ESC); add_byte(BYTE_SS3); add_byte(BYTE_DOWN);
        add_byte(BYTE_ESC); add_byte(8'h71);         // alt key
        add_byte(BYTE_ESC); add_byte(BYTE_SS3); add_byte(8'h7a);
        add_byte(BYTE_ESC); add_byte(BYTE_CSI); add_byte(8'h35); add_byte(8'h7e);
        add_byte(BYTE_ESC); add_ticks(2);           // lone esc
        add_byte(BYTE_ESC); add_byte(BYTE_CSI);
        add_item(REQ_CLOSED, 8'h00);
        add_item(REQ_UNUSED, 8'hff);
    endtask

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------

    // all queued items sent and all keys back, then let the pipe empty
    task automatic wait_drained();
        do @(negedge clk);
        while (term_input.size() != 0 || in_valid || expected_keys.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_timeout(input logic [IDLE_W-1:0] tmo);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= tmo;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid   <= 1'b0;
        timeout_cfg = tmo;
        timeout_writes++;
    endtask

    task automatic run_phase(input logic [IDLE_W-1:0] tmo, input int sidle, input int stall,
                             input int n);
        int start;
        write_timeout(tmo);
        sender_idle_pct = sidle;
        stall_pct       = stall;
        start = items_queued;
        while (items_queued - start < n) gen_unit();
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        write_timeout(10'd2);
        load_directed();

        run_phase(10'd1, 0, 0, 80);
        // timeout of zero: first tick while pending gives esc
        run_phase(10'd0, 85, 0, 80);

        run_phase(10'd1000, 0, 85, 80);
        add_item(REQ_CLOSED, 8'h00);
        add_byte(BYTE_ESC); add_byte(BYTE_CSI); add_ticks(20); add_byte(BYTE_UP);

        run_phase(10'd4, 17, 17, 80);

        // longer timeout, esc lands exactly on the last tick
        run_phase(10'd30, 0, 0, 80);
        add_item(REQ_CLOSED, 8'h00);
        add_byte(BYTE_ESC); add_ticks(30);
        add_byte(BYTE_ESC); add_byte(BYTE_SS3); add_ticks(29);
        add_item(REQ_CLOSED, 8'h00);

        wait_drained();

        $display("%0d terminal items sent, %0d keys checked, %0d timeout settings",
                 items_sent, keys_seen, timeout_writes);
        $display("%0d key mismatches, %0d keys still outstanding",
                 mismatches, expected_keys.size());
        if (mismatches == 0 && expected_keys.size() == 0) begin
            $display("tb_terminal_key_sequence_decoder passed");
        end else begin
            $display("tb_terminal_key_sequence_decoder failed");
        end
        $finish;
    end

endmodule
